>>> sv/cbb_pkg.sv
package cbb_pkg;

    localparam int COORD_BITS          = 24;
    localparam int ANGLE_FRACTION_BITS = 8;

    // coordinate difference width
    localparam int D_W          = COORD_BITS + 1;
    localparam int CORDIC_STEPS = 32;
    localparam int GUARD        = 59 - COORD_BITS;
    // |d| << GUARD stays at or below 2^59, the cordic gain and the rotation stay below 2^61
    localparam int XY_W         = 63;
    localparam int FINE_BITS    = 32;
    // angle accumulator, the table sum stays below 2^39
    localparam int Z_W          = 40;
    localparam int ZC_W         = Z_W - 1;
    localparam int F_W          = 9 + FINE_BITS;
    localparam int BEAR_W       = 9 + ANGLE_FRACTION_BITS;
    localparam int ROUND_SHIFT  = FINE_BITS - ANGLE_FRACTION_BITS;
    localparam int IN_W         = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((BEAR_W + 7) / 8) * 8;

    localparam logic [ZC_W-1:0]   Z90      = ZC_W'(90) << FINE_BITS;
    localparam logic [F_W-1:0]    FINE90   = F_W'(90) << FINE_BITS;
    localparam logic [F_W-1:0]    FINE270  = F_W'(270) << FINE_BITS;
    localparam logic [F_W:0]      HALF     = (F_W + 1)'(1) << (ROUND_SHIFT - 1);
    localparam logic [BEAR_W-1:0] FULL     = BEAR_W'(360) << ANGLE_FRACTION_BITS;
    localparam logic [BEAR_W-1:0] BEAR_90  = BEAR_W'(90) << ANGLE_FRACTION_BITS;
    localparam logic [BEAR_W-1:0] BEAR_180 = BEAR_W'(180) << ANGLE_FRACTION_BITS;
    localparam logic [BEAR_W-1:0] BEAR_270 = BEAR_W'(270) << ANGLE_FRACTION_BITS;

    // atan(2^-i) in degrees times 2^32
    localparam logic [Z_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        40'd193273528320, 40'd114096026022, 40'd60285206653, 40'd30601712202,
        40'd15360239180,  40'd7687607525,   40'd3844741806,  40'd1922488225,
        40'd961258780,    40'd480631223,    40'd240315841,   40'd120157949,
        40'd60078978,     40'd30039489,     40'd15019745,    40'd7509872,
        40'd3754936,      40'd1877468,      40'd938734,      40'd469367,
        40'd234684,       40'd117342,       40'd58671,       40'd29335,
        40'd14668,        40'd7334,         40'd3667,        40'd1833,
        40'd917,          40'd458,          40'd229,         40'd115
    };

    typedef logic signed [XY_W-1:0] cbb_xy_t;
    typedef logic signed [Z_W-1:0]  cbb_z_t;

    typedef struct packed {
        logic west;
        logic south;
        logic spec;   // on an axis or coincident, no cordic result needed
        logic on_ns;  // dx is zero
    } cbb_tag_t;

endpackage

>>> sv/compass_bearing_between_points.sv
// compass bearing of target point b seen from centre point a
//
// input stream s_*: one transaction carries both points; s_tdata holds
// centre_x, centre_y, target_x, target_y, 24-bit two's complement each.
// output stream m_*: one transaction per input transaction, in order;
// m_tdata[16:0] is the bearing in degrees times 256, clockwise from north,
// in [0, 360), upper bits zero.
//
// pipeline: each result passes through the 32-stage cordic vectoring pipeline
// plus seven stages around it
// (input, difference, magnitude, clamp, quadrant, rounding and output).
// throughput: one transaction per cycle while m_tready is high.
//
// stalls: every stage holds its item while the next one is full and blocked;
// empty stages keep filling, so s_tready stays high until all stages hold
// an item behind a stalled m_tready. nothing is dropped or repeated.
// reset clears all valid bits; the pipeline comes up empty.
module compass_bearing_between_points (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // centre_x, centre_y, target_x, target_y
    input  logic [cbb_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // bearing, zero padding
    output logic [cbb_pkg::OUT_W-1:0]   m_tdata
);

    localparam int CW = cbb_pkg::COORD_BITS;
    localparam int NS = cbb_pkg::CORDIC_STEPS;

    // input stage
    logic                v0_reg;
    logic [CW-1:0]       cx_reg, cy_reg, tx_reg, ty_reg;

    // difference stage
    logic                        v1_reg;
    logic signed [cbb_pkg::D_W-1:0] dx_reg, dy_reg, dx_next, dy_next;

    // cordic stages, index 0 loaded by the magnitude stage
    logic [NS:0]         vc_reg;
    logic [NS:0]         advc;
    cbb_pkg::cbb_xy_t    x_reg   [0:NS];
    cbb_pkg::cbb_xy_t    y_reg   [0:NS];
    cbb_pkg::cbb_z_t     z_reg   [0:NS];
    cbb_pkg::cbb_tag_t   tag_reg [0:NS];
    logic [cbb_pkg::D_W-1:0] ax_next, ay_next;
    cbb_pkg::cbb_tag_t   tag0_next;

    // finishing stages
    logic                        v3_reg, v4_reg, v5_reg, out_v_reg;
    logic [cbb_pkg::ZC_W-1:0]    zc_reg, zc_next;
    logic [cbb_pkg::F_W-1:0]     fine_reg, fine_next;
    logic [cbb_pkg::BEAR_W-1:0]  rnd_reg, rnd_next;
    logic [cbb_pkg::BEAR_W-1:0]  bear_reg, bear_next;
    logic [cbb_pkg::F_W:0]       round_sum;
    cbb_pkg::cbb_tag_t           tag3_reg, tag4_reg, tag5_reg;

    logic adv0, adv1, adv3, adv4, adv5, adv_out;

    // a stage advances when it is empty or the stage after it advances
    assign adv_out = !out_v_reg || m_tready;
    assign adv5    = !v5_reg || adv_out;
    assign adv4    = !v4_reg || adv5;
    assign adv3    = !v3_reg || adv4;

    always_comb
    begin
        advc[NS] = !vc_reg[NS] || adv3;
        for (int k = NS - 1; k >= 0; k--)
        begin
            advc[k] = !vc_reg[k] || advc[k+1];
        end
    end

    assign adv1     = !v1_reg || advc[0];
    assign adv0     = !v0_reg || adv1;
    assign s_tready = adv0;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            vc_reg    <= '0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v0_reg <= s_tvalid;
            end
            if (adv1)
            begin
                v1_reg <= v0_reg;
            end
            if (advc[0])
            begin
                vc_reg[0] <= v1_reg;
            end
            for (int k = 1; k <= NS; k++)
            begin
                if (advc[k])
                begin
                    vc_reg[k] <= vc_reg[k-1];
                end
            end
            if (adv3)
            begin
                v3_reg <= vc_reg[NS];
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv5)
            begin
                v5_reg <= v4_reg;
            end
            if (adv_out)
            begin
                out_v_reg <= v5_reg;
            end
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            cx_reg <= s_tdata[0*CW +: CW];
            cy_reg <= s_tdata[1*CW +: CW];
            tx_reg <= s_tdata[2*CW +: CW];
            ty_reg <= s_tdata[3*CW +: CW];
        end
    end

    // exact coordinate differences
    always_comb
    begin
        dx_next = $signed({tx_reg[CW-1], tx_reg}) - $signed({cx_reg[CW-1], cx_reg});
        dy_next = $signed({ty_reg[CW-1], ty_reg}) - $signed({cy_reg[CW-1], cy_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // magnitudes, quadrant and axis cases
    always_comb
    begin
        ax_next         = dx_reg[cbb_pkg::D_W-1] ? cbb_pkg::D_W'(-dx_reg) : dx_reg;
        ay_next         = dy_reg[cbb_pkg::D_W-1] ? cbb_pkg::D_W'(-dy_reg) : dy_reg;
        tag0_next.west  = dx_reg[cbb_pkg::D_W-1];
        tag0_next.south = dy_reg[cbb_pkg::D_W-1];
        tag0_next.on_ns = (dx_reg == '0);
        tag0_next.spec  = (dx_reg == '0) || (dy_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (advc[0])
        begin
            x_reg[0]   <= cbb_pkg::cbb_xy_t'(cbb_pkg::XY_W'(ax_next) << cbb_pkg::GUARD);
            y_reg[0]   <= cbb_pkg::cbb_xy_t'(cbb_pkg::XY_W'(ay_next) << cbb_pkg::GUARD);
            z_reg[0]   <= '0;
            tag_reg[0] <= tag0_next;
        end
    end

    // cordic vectoring, one rotation per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_cordic
        cbb_pkg::cbb_xy_t x_next, y_next, xs, ys;
        cbb_pkg::cbb_z_t  z_next;

        always_comb
        begin
            xs = x_reg[k] >>> k;
            ys = y_reg[k] >>> k;
            if (!y_reg[k][cbb_pkg::XY_W-1])
            begin
                x_next = x_reg[k] + ys;
                y_next = y_reg[k] - xs;
                z_next = z_reg[k] + cbb_pkg::cbb_z_t'(cbb_pkg::ATAN_TABLE[k]);
            end
            else
            begin
                x_next = x_reg[k] - ys;
                y_next = y_reg[k] + xs;
                z_next = z_reg[k] - cbb_pkg::cbb_z_t'(cbb_pkg::ATAN_TABLE[k]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (advc[k+1])
            begin
                x_reg[k+1]   <= x_next;
                y_reg[k+1]   <= y_next;
                z_reg[k+1]   <= z_next;
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    // clamp to [0, 90] degrees
    always_comb
    begin
        if (z_reg[NS][cbb_pkg::Z_W-1])
        begin
            zc_next = '0;
        end
        else if (z_reg[NS][cbb_pkg::ZC_W-1:0] > cbb_pkg::Z90)
        begin
            zc_next = cbb_pkg::Z90;
        end
        else
        begin
            zc_next = z_reg[NS][cbb_pkg::ZC_W-1:0];
        end
    end

    // quadrant correction: east side from 90, west side from 270
    always_comb
    begin
        logic [cbb_pkg::F_W-1:0] base;
        base = tag3_reg.west ? cbb_pkg::FINE270 : cbb_pkg::FINE90;
        if (tag3_reg.west ^ tag3_reg.south)
        begin
            fine_next = base + cbb_pkg::F_W'(zc_reg);
        end
        else
        begin
            fine_next = base - cbb_pkg::F_W'(zc_reg);
        end
    end

    // round half up to the output fraction
    always_comb
    begin
        round_sum = {1'b0, fine_reg} + cbb_pkg::HALF;
        rnd_next  = round_sum[cbb_pkg::ROUND_SHIFT +: cbb_pkg::BEAR_W];
    end

    // wrap 360 to 0, axis cases take exact values
    always_comb
    begin
        if (tag5_reg.spec)
        begin
            if (tag5_reg.on_ns)
            begin
                bear_next = tag5_reg.south ? cbb_pkg::BEAR_180 : '0;
            end
            else
            begin
                bear_next = tag5_reg.west ? cbb_pkg::BEAR_270 : cbb_pkg::BEAR_90;
            end
        end
        else if (rnd_reg >= cbb_pkg::FULL)
        begin
            bear_next = rnd_reg - cbb_pkg::FULL;
        end
        else
        begin
            bear_next = rnd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            zc_reg   <= zc_next;
            tag3_reg <= tag_reg[NS];
        end
        if (adv4)
        begin
            fine_reg <= fine_next;
            tag4_reg <= tag3_reg;
        end
        if (adv5)
        begin
            rnd_reg  <= rnd_next;
            tag5_reg <= tag4_reg;
        end
        if (adv_out)
        begin
            bear_reg <= bear_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = cbb_pkg::OUT_W'(bear_reg);

endmodule

>>> sv/cbb_checker.sv
module cbb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [cbb_pkg::IN_W-1:0]    s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [cbb_pkg::OUT_W-1:0]   m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // bearing stays below 360 degrees
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[cbb_pkg::BEAR_W-1:0] < cbb_pkg::FULL)
        else $error("bearing out of range");

    // padding above the bearing is zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >> cbb_pkg::BEAR_W) == '0)
        else $error("nonzero padding in m_tdata");

    // a free-running output side never backs up the pipeline
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input blocked while output side is ready");

    // an accepted transaction carries known coordinates
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !$isunknown(s_tdata))
        else $error("unknown bits in accepted s_tdata");

endmodule

bind compass_bearing_between_points cbb_checker u_cbb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
